FILE: design/dos_path_name_checker_defines.svh
// Assertion macros for the path checker's assertion file, dpc_checker.sv.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef DOS_PATH_NAME_CHECKER_DEFINES_SVH
`define DOS_PATH_NAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpc check failed");

// Next-cycle implication, disabled during reset.
`define DPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpc check failed");

`endif

FILE: design/dpc_pkg.sv
// Package for the path checker: character codes, parse phase codes,
// verdict codes and the parser state struct. No dependencies.
package dpc_pkg;

    localparam int RUN_W   = 4;
    localparam int PHASE_W = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_COLON  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DOT1   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DOT2   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SEP    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_NAME   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_SUFDOT = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SUFFIX = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ERROR  = 4'd9;

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_REL     = 2'd1;
    localparam logic [1:0] VERDICT_ABS     = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [RUN_W-1:0]   run_len;
        logic               has_drive;
    } dpc_state_t;

    localparam dpc_state_t STATE_RESET = '{phase: PH_START, run_len: '0, has_drive: 1'b0};

endpackage

FILE: design/dos_path_name_checker.sv
// DOS 8.3 path checker, one character per beat, one verdict per path.
// A final character's beat waits in the input register, and its verdict is registered
// in the result register, from which it shows at the output.
// Throughput: one character per cycle, set by the combinational parser step; a final
// character waits in the input register only while the previous verdict is unread.
// Reset (rst_n low, asynchronous) empties both registers and restarts parsing.
module dos_path_name_checker #(
    parameter int NAME_MAX_LEN   = 8,
    parameter int SUFFIX_MAX_LEN = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] verdict
);

    // Input register: holds one accepted character beat.
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          char_reg;
    logic                last_reg;

    // Parser state carried between characters of one path.
    dpc_pkg::dpc_state_t state_reg;
    dpc_pkg::dpc_state_t state_next;
    dpc_pkg::dpc_state_t step_state;
    logic [1:0]          step_verdict;

    // Result register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [1:0]          verdict_reg;

    logic                accept;
    logic                fire;

    dpc_step #(
        .NAME_MAX_LEN   (NAME_MAX_LEN),
        .SUFFIX_MAX_LEN (SUFFIX_MAX_LEN)
    ) u_step (
        .state_cur  (state_reg),
        .char_code  (char_reg),
        .last_char  (last_reg),
        .state_next (step_state),
        .verdict    (step_verdict)
    );

    // Advance the held beat unless it is a final character whose verdict
    // cannot move into a result register that is still occupied.
    assign fire     = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    assign state_next = fire ? step_state : state_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && last_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= dpc_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on their beat, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (fire && last_reg)
            verdict_reg <= step_verdict;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

FILE: design/dpc_step.sv
// Parser step: folds case, advances the parse state by one character and
// forms the verdict for a final character. Depends on dpc_pkg.
module dpc_step #(
    parameter int NAME_MAX_LEN   = 8,
    parameter int SUFFIX_MAX_LEN = 3
) (
    input  dpc_pkg::dpc_state_t state_cur,
    input  logic [7:0]          char_code,
    input  logic                last_char,
    output dpc_pkg::dpc_state_t state_next,
    output logic [1:0]          verdict
);

    localparam logic [dpc_pkg::RUN_W-1:0] NAME_LIM = dpc_pkg::RUN_W'(NAME_MAX_LEN);
    localparam logic [dpc_pkg::RUN_W-1:0] SUF_LIM  = dpc_pkg::RUN_W'(SUFFIX_MAX_LEN);

    logic [7:0]          ch;
    logic                is_letter;
    logic                is_dot;
    logic                is_bslash;
    dpc_pkg::dpc_state_t adv;
    dpc_pkg::dpc_state_t in_name;
    logic                accepts;

    always_comb
    begin
        ch = char_code;
        if (char_code >= dpc_pkg::CH_LOWER_A && char_code <= dpc_pkg::CH_LOWER_Z)
        begin
            ch = char_code - dpc_pkg::CASE_DELTA;
        end
    end

    assign is_letter = (ch >= dpc_pkg::CH_UPPER_A) && (ch <= dpc_pkg::CH_UPPER_Z);
    assign is_dot    = (ch == dpc_pkg::CH_DOT);
    assign is_bslash = (ch == dpc_pkg::CH_BSLASH);

    // Character inside a name: extend it, open a suffix or close it.
    always_comb
    begin
        in_name = state_cur;
        if (is_letter)
        begin
            if (state_cur.run_len >= NAME_LIM)
            begin
                in_name.phase = dpc_pkg::PH_ERROR;
            end
            else
            begin
                in_name.run_len = state_cur.run_len + 1'b1;
                in_name.phase   = dpc_pkg::PH_NAME;
            end
        end
        else if (is_dot)
        begin
            in_name.run_len = '0;
            in_name.phase   = dpc_pkg::PH_SUFDOT;
        end
        else if (is_bslash)
        begin
            in_name.run_len = '0;
            in_name.phase   = dpc_pkg::PH_SEP;
        end
        else
        begin
            in_name.phase = dpc_pkg::PH_ERROR;
        end
    end

    always_comb
    begin
        adv = state_cur;
        case (state_cur.phase)
            dpc_pkg::PH_START:
            begin
                if (is_letter)
                begin
                    adv.run_len = dpc_pkg::RUN_W'(1);
                    adv.phase   = dpc_pkg::PH_FIRST;
                end
                else if (is_dot)
                    adv.phase = dpc_pkg::PH_DOT1;
                else if (is_bslash)
                    adv.phase = dpc_pkg::PH_SEP;
                else
                    adv.phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_FIRST:
            begin
                if (ch == dpc_pkg::CH_COLON)
                begin
                    adv.has_drive = 1'b1;
                    adv.run_len   = '0;
                    adv.phase     = dpc_pkg::PH_COLON;
                end
                else
                    adv = in_name;
            end
            dpc_pkg::PH_COLON,
            dpc_pkg::PH_DOT2:
            begin
                adv.phase = is_bslash ? dpc_pkg::PH_SEP : dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_DOT1:
            begin
                if (is_dot)
                    adv.phase = dpc_pkg::PH_DOT2;
                else if (is_bslash)
                    adv.phase = dpc_pkg::PH_SEP;
                else
                    adv.phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_SEP:
            begin
                if (is_letter)
                begin
                    adv.run_len = dpc_pkg::RUN_W'(1);
                    adv.phase   = dpc_pkg::PH_NAME;
                end
                else
                    adv.phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_NAME:
            begin
                adv = in_name;
            end
            dpc_pkg::PH_SUFDOT:
            begin
                if (is_letter)
                begin
                    adv.run_len = dpc_pkg::RUN_W'(1);
                    adv.phase   = dpc_pkg::PH_SUFFIX;
                end
                else
                    adv.phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_SUFFIX:
            begin
                if (is_letter)
                begin
                    if (state_cur.run_len >= SUF_LIM)
                        adv.phase = dpc_pkg::PH_ERROR;
                    else
                        adv.run_len = state_cur.run_len + 1'b1;
                end
                else if (is_bslash)
                begin
                    adv.run_len = '0;
                    adv.phase   = dpc_pkg::PH_SEP;
                end
                else
                    adv.phase = dpc_pkg::PH_ERROR;
            end
            default:
            begin
                adv.phase = dpc_pkg::PH_ERROR;
            end
        endcase
    end

    assign accepts = (adv.phase == dpc_pkg::PH_FIRST) || (adv.phase == dpc_pkg::PH_SEP) ||
                     (adv.phase == dpc_pkg::PH_NAME)  || (adv.phase == dpc_pkg::PH_SUFFIX);

    always_comb
    begin
        verdict = dpc_pkg::VERDICT_INVALID;
        if (accepts)
            verdict = adv.has_drive ? dpc_pkg::VERDICT_ABS : dpc_pkg::VERDICT_REL;
    end

    // Start a fresh path after the final character.
    assign state_next = last_char ? dpc_pkg::STATE_RESET : adv;

endmodule

FILE: design/dpc_checker.sv
// Port-level assertions for the path checker and the bind that attaches them.
// Depends on dpc_pkg and dos_path_name_checker_defines.svh.
`include "dos_path_name_checker_defines.svh"

module dpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict
);

    // Only the three defined verdict codes leave the block.
    `DPC_ASSERT_NOW(a_verdict_code, out_valid, verdict <= dpc_pkg::VERDICT_ABS)

    // Input backpressure only while a result is stuck at the output.
    `DPC_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)

    // A waiting result holds its value.
    `DPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict))

    // A blocked input opens exactly when the waiting result is taken.
    `DPC_ASSERT_NEXT(a_stall_release, !in_ready, in_ready == out_ready)

endmodule

bind dos_path_name_checker dpc_checker u_dpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
);

FILE: tb/testbench.sv
// Self-checking testbench for dos_path_name_checker: directed and random paths,
// checked against an in-bench model of the 8.3 path grammar.
// Depends on dpc_pkg for character and verdict codes and on the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Grammar limits; these match the block's default parameters.
    localparam int NAME_LIMIT   = 8;
    localparam int SUFFIX_LIMIT = 3;

    localparam int DRAIN_CYCLES   = 8;
    localparam int SHOW_ERRORS    = 10;
    localparam int STALL_CYCLES   = 400;
    localparam int STALL_PATHS    = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'h00;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] verdict;

    dos_path_name_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    always #5 clk = ~clk;

    // Idle rates in percent for each side, changed from test to test.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off: a test posts a length, the receiver process
    // takes it over and counts it down on its own.
    int stall_request = 0;
    int stall_left    = 0;

    // Parser state of the bench's own model of the path grammar.
    logic [3:0] path_phase   = dpc_pkg::PH_START;
    logic [3:0] letter_count = '0;
    logic       drive_seen   = 1'b0;

    // Verdicts owed by the block, oldest first.
    logic [1:0] verdict_q[$];

    // Bytes of the path under construction for the random tests.
    logic [7:0] path_buf[$];

    int error_count   = 0;
    int chars_sent    = 0;
    int paths_sent    = 0;
    int verdicts_seen = 0;
    int verdict_tally[3] = '{0, 0, 0};

    //------------------------------------------------------------------
    // Path grammar model
    //------------------------------------------------------------------

    function automatic logic is_alpha(input logic [7:0] c);
        return c >= dpc_pkg::CH_UPPER_A && c <= dpc_pkg::CH_UPPER_Z;
    endfunction

    // Handle one byte inside a name of letter_count letters.
    task automatic name_char(input logic [7:0] c);
        if (is_alpha(c))
        begin
            if (letter_count >= NAME_LIMIT)
            begin
                path_phase = dpc_pkg::PH_ERROR;
            end
            else
            begin
                letter_count = letter_count + 4'd1;
                path_phase   = dpc_pkg::PH_NAME;
            end
        end
        else if (c == dpc_pkg::CH_DOT)
        begin
            letter_count = '0;
            path_phase   = dpc_pkg::PH_SUFDOT;
        end
        else if (c == dpc_pkg::CH_BSLASH)
        begin
            letter_count = '0;
            path_phase   = dpc_pkg::PH_SEP;
        end
        else
        begin
            path_phase = dpc_pkg::PH_ERROR;
        end
    endtask

    // Advance the model by one accepted character; on the final one queue
    // the verdict the block owes and restart at the head of a new path.
    task automatic parse_char(input logic [7:0] raw, input logic is_last);
        logic [7:0] c;
        logic [1:0] owed;
        c = raw;
        if (raw >= dpc_pkg::CH_LOWER_A && raw <= dpc_pkg::CH_LOWER_Z)
            c = raw - dpc_pkg::CASE_DELTA;
        case (path_phase)
            dpc_pkg::PH_START:
            begin
                if (is_alpha(c))
                begin
                    letter_count = 4'd1;
                    path_phase   = dpc_pkg::PH_FIRST;
                end
                else if (c == dpc_pkg::CH_DOT)
                    path_phase = dpc_pkg::PH_DOT1;
                else if (c == dpc_pkg::CH_BSLASH)
                    path_phase = dpc_pkg::PH_SEP;
                else
                    path_phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_FIRST:
            begin
                if (c == dpc_pkg::CH_COLON)
                begin
                    drive_seen   = 1'b1;
                    letter_count = '0;
                    path_phase   = dpc_pkg::PH_COLON;
                end
                else
                begin
                    name_char(c);
                end
            end
            dpc_pkg::PH_COLON, dpc_pkg::PH_DOT2:
            begin
                path_phase = (c == dpc_pkg::CH_BSLASH) ? dpc_pkg::PH_SEP : dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_DOT1:
            begin
                if (c == dpc_pkg::CH_DOT)
                    path_phase = dpc_pkg::PH_DOT2;
                else if (c == dpc_pkg::CH_BSLASH)
                    path_phase = dpc_pkg::PH_SEP;
                else
                    path_phase = dpc_pkg::PH_ERROR;
            end
            dpc_pkg::PH_SEP:
            begin
                if (is_alpha(c))
                begin
                    letter_count = 4'd1;
                    path_phase   = dpc_pkg::PH_NAME;
                end
                else
                begin
                    path_phase = dpc_pkg::PH_ERROR;
                end
            end
            dpc_pkg::PH_NAME:
            begin
                name_char(c);
            end
            dpc_pkg::PH_SUFDOT:
            begin
                if (is_alpha(c))
                begin
                    letter_count = 4'd1;
                    path_phase   = dpc_pkg::PH_SUFFIX;
                end
                else
                begin
                    path_phase = dpc_pkg::PH_ERROR;
                end
            end
            dpc_pkg::PH_SUFFIX:
            begin
                if (is_alpha(c))
                begin
                    if (letter_count >= SUFFIX_LIMIT)
                        path_phase = dpc_pkg::PH_ERROR;
                    else
                        letter_count = letter_count + 4'd1;
                end
                else if (c == dpc_pkg::CH_BSLASH)
                begin
                    letter_count = '0;
                    path_phase   = dpc_pkg::PH_SEP;
                end
                else
                begin
                    path_phase = dpc_pkg::PH_ERROR;
                end
            end
            default:
            begin
                path_phase = dpc_pkg::PH_ERROR;
            end
        endcase

        if (is_last)
        begin
            if (path_phase == dpc_pkg::PH_FIRST || path_phase == dpc_pkg::PH_SEP ||
                path_phase == dpc_pkg::PH_NAME || path_phase == dpc_pkg::PH_SUFFIX)
                owed = drive_seen ? dpc_pkg::VERDICT_ABS : dpc_pkg::VERDICT_REL;
            else
                owed = dpc_pkg::VERDICT_INVALID;
            verdict_q.push_back(owed);
            verdict_tally[owed]++;
            paths_sent++;
            path_phase   = dpc_pkg::PH_START;
            letter_count = '0;
            drive_seen   = 1'b0;
        end
    endtask

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------

    // Offer one character beat. Drive at the falling edge, look for the
    // handshake at the rising edge, and hold the payload until it is taken.
    // While idle, scramble the payload so every input bit toggles.
    task automatic send_char(input logic [7:0] code, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid  = 1'b0;
            char_code = 8'($urandom_range(0, 255));
            last_char = 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        in_valid  = 1'b1;
        char_code = code;
        last_char = is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_char(code, is_last);
        chars_sent++;
    endtask

    // Send a whole path written as text; the final character is marked last.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(8'(s[i]), i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? dpc_pkg::CH_UPPER_A : dpc_pkg::CH_LOWER_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    // Build one random path in path_buf. Most are well formed with random
    // names and lengths near the limits; some get one byte broken, and a
    // few are plain noise.
    task automatic make_path();
        int kind;
        int names;
        int len;
        int r;
        int idx;
        path_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            repeat ($urandom_range(1, 6))
                path_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // Prefix: none, drive, dot, dot-dot or a leading backslash.
        case ($urandom_range(0, 5))
            1, 5:
            begin
                path_buf.push_back(rand_letter());
                path_buf.push_back(dpc_pkg::CH_COLON);
                path_buf.push_back(dpc_pkg::CH_BSLASH);
            end
            2:
            begin
                path_buf.push_back(dpc_pkg::CH_DOT);
                path_buf.push_back(dpc_pkg::CH_BSLASH);
            end
            3:
            begin
                path_buf.push_back(dpc_pkg::CH_DOT);
                path_buf.push_back(dpc_pkg::CH_DOT);
                path_buf.push_back(dpc_pkg::CH_BSLASH);
            end
            4:
            begin
                path_buf.push_back(dpc_pkg::CH_BSLASH);
            end
            default: ;
        endcase

        names = $urandom_range(0, 3);
        for (int n = 0; n < names; n++)
        begin
            if (n > 0)
                path_buf.push_back(dpc_pkg::CH_BSLASH);
            r   = $urandom_range(0, 99);
            len = (r < 4) ? 0 : (r < 12) ? NAME_LIMIT + 1 : $urandom_range(1, NAME_LIMIT);
            repeat (len)
                path_buf.push_back(rand_letter());
            if ($urandom_range(0, 99) < 40)
            begin
                path_buf.push_back(dpc_pkg::CH_DOT);
                r   = $urandom_range(0, 99);
                len = (r < 6) ? 0 : (r < 14) ? SUFFIX_LIMIT + 1
                                               : $urandom_range(1, SUFFIX_LIMIT);
                repeat (len)
                    path_buf.push_back(rand_letter());
            end
        end
        if ($urandom_range(0, 99) < 20)
            path_buf.push_back(dpc_pkg::CH_BSLASH);
        if (path_buf.size() == 0)
            path_buf.push_back(rand_letter());

        // Break one byte: a separator in the wrong place or any value.
        if (kind >= 90)
        begin
            idx = $urandom_range(0, path_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: path_buf[idx] = dpc_pkg::CH_COLON;
                1: path_buf[idx] = dpc_pkg::CH_DOT;
                2: path_buf[idx] = dpc_pkg::CH_BSLASH;
                default: path_buf[idx] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    //------------------------------------------------------------------
    // Output side
    //------------------------------------------------------------------

    // Receiver: drop ready at random, or for the whole of a posted hold-off.
    always @(negedge clk)
    begin
        if (stall_request != 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every verdict beat against the oldest owed verdict.
    always @(posedge clk)
    begin : check_verdict
        logic [1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOW_ERRORS)
                    $display("%0t: verdict %0d arrived with none owed", $realtime, verdict);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (verdict !== want)
                begin
                    error_count++;
                    if (error_count <= SHOW_ERRORS)
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $realtime, want, verdict);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Short paths covering the edge cases of the grammar and the byte range.
    task automatic test_directed();
        send_idle_pct = 32;
        recv_idle_pct = 45;
        send_text("z");            // single lower-case letter, folded, a name
        send_text("\\");           // leading backslash alone
        send_text("a:");           // ends right after the drive colon
        send_text("..");           // ends after dot-dot
        send_text("A:\\B.C");      // drive, name and suffix
        send_text("\\\\");         // empty name between separators
        send_text("A.");           // ends on the suffix dot
        send_text("A.BCDE");       // suffix one letter too long
        send_char(8'h00, 1'b1);    // lowest byte, illegal
        send_char(8'hFF, 1'b0);    // highest byte, then the rest is ignored
        send_char(dpc_pkg::CH_UPPER_A, 1'b1);
    endtask

    // Random paths until about char_target characters have gone in.
    task automatic test_random_paths(input int send_pct, input int recv_pct,
                                     input int char_target);
        int start_chars;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_chars   = chars_sent;
        while (chars_sent - start_chars < char_target)
        begin
            make_path();
            foreach (path_buf[i])
                send_char(path_buf[i], i == path_buf.size() - 1);
        end
    endtask

    // Hold the receiver off for a long stretch while one-letter paths keep
    // coming, so the block fills up and has to back-pressure its input.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = STALL_CYCLES;
        repeat (STALL_PATHS)
            send_char(rand_letter(), 1'b1);
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial
    begin
        // Hold reset, then release it away from the rising edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_paths(32, 45, 700);
        test_output_stall();
        test_random_paths(45, 32, 700);
        test_random_paths(0, 0, 600);

        // Stop offering beats, then wait out every owed verdict.
        @(negedge clk);
        in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (verdict_q.size() != 0)
        begin
            error_count++;
            $display("%0d verdicts still owed at the end", verdict_q.size());
        end

        $display("Covered %0d characters in %0d paths (%0d verdicts taken): %0d invalid,",
                 chars_sent, paths_sent, verdicts_seen, verdict_tally[dpc_pkg::VERDICT_INVALID]);
        $display("%0d relative, %0d absolute; both idle mixes, no idle, a %0d-cycle hold-off.",
                 verdict_tally[dpc_pkg::VERDICT_REL], verdict_tally[dpc_pkg::VERDICT_ABS],
                 STALL_CYCLES);

        if (error_count == 0)
            $display("PASS dos_path_name_checker");
        else
            $display("FAIL dos_path_name_checker");
        $finish;
    end

    // Watchdog: the slowest correct run ends far sooner than this.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d verdicts owed", verdict_q.size());
        $display("FAIL dos_path_name_checker");
        $finish;
    end

endmodule
